FILE: rtl/vdgr_pkg.sv
package vdgr_pkg;

  localparam int ACTION_W = 2;
  localparam int DISP_W   = 8;
  localparam int ROW_W    = 10;
  localparam int COLOR_W  = 24;
  localparam int TOL_W    = 8;
  localparam int CNT_W    = 8;
  localparam int SUMD_W   = 16;
  localparam int SUMR_W   = 18;
  localparam int EXP_W    = 20;
  localparam int CROW_W   = ROW_W + 1;

  // shared multiplier and line arithmetic
  localparam int MUL_W  = 20;
  localparam int PROD_W = 2 * MUL_W;
  localparam int NUM_W  = 37;
  localparam int MAG_W  = NUM_W - 1;
  localparam int DEN_W  = 26;

  localparam int DEF_MAX_SEGMENTS  = 255;
  localparam int DEF_MAX_ROWS      = 1024;
  localparam int DEF_FRACTION_BITS = 8;

  localparam logic [TOL_W-1:0]         TOL_RESET   = TOL_W'(10);
  localparam logic [CROW_W-1:0]        ROW_INVALID = '1;
  localparam logic signed [EXP_W-1:0]  EXP_MAX     = {1'b0, {(EXP_W-1){1'b1}}};
  localparam logic signed [EXP_W-1:0]  EXP_MIN     = {1'b1, {(EXP_W-1){1'b0}}};

  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_PIXEL = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_RN,
    ST_MUL_TD,
    ST_MUL_SD,
    ST_MUL_ND,
    ST_PREP,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

FILE: rtl/vdgr_if.sv
interface vdgr_in_if import vdgr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [DISP_W-1:0]   seg_disp_a;
  logic [ROW_W-1:0]    seg_row_a;
  logic [DISP_W-1:0]   seg_disp_b;
  logic [ROW_W-1:0]    seg_row_b;
  logic [ROW_W-1:0]    pixel_row;
  logic [DISP_W-1:0]   pixel_disparity;
  logic [COLOR_W-1:0]  pixel_color;

  modport source (
    output valid, action, seg_disp_a, seg_row_a, seg_disp_b, seg_row_b,
           pixel_row, pixel_disparity, pixel_color,
    input  ready
  );
  modport sink (
    input  valid, action, seg_disp_a, seg_row_a, seg_disp_b, seg_row_b,
           pixel_row, pixel_disparity, pixel_color,
    output ready
  );
endinterface

interface vdgr_out_if import vdgr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DISP_W-1:0]  disparity_out;
  logic [COLOR_W-1:0] color_out;
  logic               is_ground;

  modport source (output valid, disparity_out, color_out, is_ground, input ready);
  modport sink   (input valid, disparity_out, color_out, is_ground, output ready);
endinterface

FILE: rtl/vdgr_div.sv
module vdgr_div import vdgr_pkg::*; #(
  parameter int DVD_W = 46,
  parameter int DVS_W = 27,
  parameter int Q_W   = 19
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [Q_W-1:0]   quotient,
  output div_stat_t        stat
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] rem_nxt;
  logic [DVS_W:0]   rem_sh;
  logic [Q_W-1:0]   q_r;
  logic             ovf_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             qbit;

  // one restoring step per cycle, dividend MSB first
  always_comb begin
    rem_sh  = {rem_r, dvd_r[DVD_W-1]};
    qbit    = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = qbit ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      q_r   <= {q_r[Q_W-2:0], qbit};
      // keep a sticky flag for quotient bits beyond the saturation range
      ovf_r <= ovf_r | q_r[Q_W-1];
    end
  end

  assign quotient  = q_r;
  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;

endmodule

FILE: rtl/vdisparity_ground_removal.sv
// Channel  Dir  Word
// in_ch    in   action, segment ends (disp/row a and b), pixel row/disparity/color
// out_ch   out  disparity_out, color_out, is_ground (one word per pixel action)
// cfg      in   cfg_we/cfg_data: ground_tolerance, no read-back
//
// Clear, add and pixels on the cached row (or with no usable line) leave in_ch.ready high.
// A pixel on a new row holds in_ch.ready low through four passes
// through the shared 20x20 multiplier, two setup steps, one quotient bit per cycle for each
// dividend bit in the restoring divider, then a step to take the quotient and one
// to load the output word, which waits while out_ch stalls.
// Reset is synchronous, active low; sums clear, tolerance returns to 10.
// A result stalled on out_ch is held in the output register; one more pixel
// may be taken and waits until the register frees.
module vdisparity_ground_removal import vdgr_pkg::*; #(
  parameter int MAX_SEGMENTS  = DEF_MAX_SEGMENTS,
  parameter int MAX_ROWS      = DEF_MAX_ROWS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  vdgr_in_if.sink           in_ch,
  vdgr_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [TOL_W-1:0]  cfg_data
);

  localparam int FB     = FRACTION_BITS;
  localparam int DVD_W  = MAG_W + FB + 2;
  localparam int DVS_W  = DEN_W + 1;
  localparam int Q_W    = EXP_W - 1;
  localparam int SD_W   = DISP_W + FB + 1;
  localparam int DIFF_W = ((SD_W > EXP_W) ? SD_W : EXP_W) + 1;
  localparam int LIM_W  = TOL_W + FB;
  localparam int CMP_W  = (DIFF_W > LIM_W) ? DIFF_W : LIM_W;
  localparam logic [ROW_W:0] ROW_LIM = (MAX_ROWS >= (1 << ROW_W)) ?
                                       (ROW_W+1)'(1 << ROW_W) : (ROW_W+1)'(MAX_ROWS);

  function automatic logic classify(input logic [DISP_W-1:0]       d,
                                    input logic signed [EXP_W-1:0] e,
                                    input logic [TOL_W-1:0]        t);
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag;
    logic [LIM_W-1:0]         lim;
    diff = $signed(DIFF_W'({d, {FB{1'b0}}})) - DIFF_W'(e);
    mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    lim  = {t, {FB{1'b0}}};
    return CMP_W'(mag) < CMP_W'(lim);
  endfunction

  state_t state_r, state_nxt;

  logic [TOL_W-1:0]         tol_r;
  logic [CNT_W-1:0]         count_r;
  logic [SUMD_W-1:0]        sum_da_r, sum_db_r;
  logic [SUMR_W-1:0]        sum_ra_r, sum_rb_r;
  logic [CROW_W-1:0]        cached_row_r;
  logic signed [EXP_W-1:0]  exp_r;

  logic [ROW_W-1:0]         pix_row_r;
  logic [DISP_W-1:0]        pix_disp_r;
  logic [COLOR_W-1:0]       pix_color_r;
  logic                     pix_en_r;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [NUM_W-1:0]  num_r;
  logic [MAG_W-1:0]         mag_r;
  logic [DEN_W-1:0]         uden_r;
  logic                     neg_r;

  logic                     out_valid_r;
  logic [DISP_W-1:0]        out_disp_r, out_disp_nxt;
  logic [COLOR_W-1:0]       out_color_r, out_color_nxt;
  logic                     out_gnd_r, out_gnd_nxt;
  logic                     load_out;

  logic                     accept, slot_free, usable, en_in, need_calc, gnd;
  logic signed [SUMD_W:0]   dd;
  logic signed [SUMR_W:0]   dr;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [EXP_W-1:0]  exp_new;
  logic [Q_W-1:0]           quot;
  div_stat_t                div_stat;
  logic                     div_start;

  assign accept    = in_ch.valid & in_ch.ready;
  assign slot_free = ~out_valid_r | out_ch.ready;
  assign usable    = (count_r != '0) && (sum_ra_r != sum_rb_r);
  assign en_in     = usable && ({1'b0, in_ch.pixel_row} < ROW_LIM);
  assign need_calc = en_in && (cached_row_r != {1'b0, in_ch.pixel_row});
  assign dd        = $signed({1'b0, sum_db_r}) - $signed({1'b0, sum_da_r});
  assign dr        = $signed({1'b0, sum_rb_r}) - $signed({1'b0, sum_ra_r});
  assign div_start = (state_r == ST_DIV_GO);

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.disparity_out = out_disp_r;
  assign out_ch.color_out     = out_color_r;
  assign out_ch.is_ground     = out_gnd_r;

  // shared multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUL_RN: begin
        mul_a = $signed(MUL_W'(pix_row_r));
        mul_b = $signed(MUL_W'(count_r));
      end
      ST_MUL_TD: begin
        mul_a = $signed(prod_r[MUL_W-1:0] - MUL_W'(sum_rb_r));
        mul_b = MUL_W'(dd);
      end
      ST_MUL_SD: begin
        mul_a = $signed(MUL_W'(sum_db_r));
        mul_b = MUL_W'(dr);
      end
      ST_MUL_ND: begin
        mul_a = $signed(MUL_W'(count_r));
        mul_b = MUL_W'(dr);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    if (div_stat.ovf) begin
      exp_new = neg_r ? EXP_MIN : EXP_MAX;
    end else if (neg_r) begin
      exp_new = -$signed({1'b0, quot});
    end else begin
      exp_new = $signed({1'b0, quot});
    end
  end

  always_comb begin
    state_nxt     = state_r;
    load_out      = 1'b0;
    gnd           = 1'b0;
    out_disp_nxt  = pix_disp_r;
    out_color_nxt = pix_color_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_ch.action == ACT_PIXEL) begin
          if (need_calc) begin
            state_nxt = ST_MUL_RN;
          end else if (slot_free) begin
            load_out      = 1'b1;
            gnd           = en_in && classify(in_ch.pixel_disparity, exp_r, tol_r);
            out_disp_nxt  = in_ch.pixel_disparity;
            out_color_nxt = in_ch.pixel_color;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_MUL_RN:   state_nxt = ST_MUL_TD;
      ST_MUL_TD:   state_nxt = ST_MUL_SD;
      ST_MUL_SD:   state_nxt = ST_MUL_ND;
      ST_MUL_ND:   state_nxt = ST_PREP;
      ST_PREP:     state_nxt = ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          load_out  = 1'b1;
          gnd       = pix_en_r && classify(pix_disp_r, exp_r, tol_r);
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_gnd_nxt = gnd;
    if (gnd) begin
      out_disp_nxt  = '0;
      out_color_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // segment sums, line cache and tolerance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r        <= TOL_RESET;
      count_r      <= '0;
      sum_da_r     <= '0;
      sum_ra_r     <= '0;
      sum_db_r     <= '0;
      sum_rb_r     <= '0;
      cached_row_r <= ROW_INVALID;
      exp_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        tol_r <= cfg_data;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_DIV_WAIT && div_stat.done) begin
        exp_r        <= exp_new;
        cached_row_r <= {1'b0, pix_row_r};
      end
      if (accept) begin
        case (in_ch.action)
          ACT_CLEAR: begin
            count_r      <= '0;
            sum_da_r     <= '0;
            sum_ra_r     <= '0;
            sum_db_r     <= '0;
            sum_rb_r     <= '0;
            cached_row_r <= ROW_INVALID;
            exp_r        <= '0;
          end
          ACT_ADD: begin
            if (count_r < CNT_W'(MAX_SEGMENTS)) begin
              count_r  <= count_r + CNT_W'(1);
              sum_da_r <= sum_da_r + SUMD_W'(in_ch.seg_disp_a);
              sum_ra_r <= sum_ra_r + SUMR_W'(in_ch.seg_row_a);
              sum_db_r <= sum_db_r + SUMD_W'(in_ch.seg_disp_b);
              sum_rb_r <= sum_rb_r + SUMR_W'(in_ch.seg_row_b);
            end
            cached_row_r <= ROW_INVALID;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // pixel hold, line arithmetic and output words
  always_ff @(posedge clk) begin
    if (accept && in_ch.action == ACT_PIXEL) begin
      pix_row_r   <= in_ch.pixel_row;
      pix_disp_r  <= in_ch.pixel_disparity;
      pix_color_r <= in_ch.pixel_color;
      pix_en_r    <= en_in;
    end
    prod_r <= mul_a * mul_b;
    case (state_r)
      ST_MUL_SD: num_r <= prod_r[NUM_W-1:0];
      ST_MUL_ND: num_r <= num_r + prod_r[NUM_W-1:0];
      ST_PREP: begin
        // prod_r now holds the denominator; fold both signs into neg_r
        neg_r  <= num_r[NUM_W-1] ^ prod_r[PROD_W-1];
        mag_r  <= num_r[NUM_W-1] ? MAG_W'(-num_r) : MAG_W'(num_r);
        uden_r <= prod_r[PROD_W-1] ? DEN_W'(-prod_r) : DEN_W'(prod_r);
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_disp_r  <= out_disp_nxt;
      out_color_r <= out_color_nxt;
      out_gnd_r   <= out_gnd_nxt;
    end
  end

  // round to nearest: (mag * 2^(FB+1) + den) / (2 * den)
  vdgr_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W),
    .Q_W   (Q_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DVD_W'({mag_r, {(FB+1){1'b0}}}) + DVD_W'(uden_r)),
    .divisor  ({uden_r, 1'b0}),
    .quotient (quot),
    .stat     (div_stat)
  );

endmodule

FILE: tb/sv/tb_vdisparity_ground_removal.sv
module tb_vdisparity_ground_removal;
  import vdgr_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 80;
  localparam int QUIET_LIMIT    = 3000;
  localparam int RANDOM_WORDS   = 40;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [DISP_W-1:0]   seg_disp_a;
    logic [ROW_W-1:0]    seg_row_a;
    logic [DISP_W-1:0]   seg_disp_b;
    logic [ROW_W-1:0]    seg_row_b;
    logic [ROW_W-1:0]    pixel_row;
    logic [DISP_W-1:0]   pixel_disparity;
    logic [COLOR_W-1:0]  pixel_color;
  } in_word_t;

  typedef struct packed {
    logic [DISP_W-1:0]  disparity;
    logic [COLOR_W-1:0] color;
    logic               ground;
  } pixel_word_t;

  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [SUMD_W-1:0] disp_a;
    logic [SUMR_W-1:0] row_a;
    logic [SUMD_W-1:0] disp_b;
    logic [SUMR_W-1:0] row_b;
  } seg_sums_t;

  typedef struct {
    in_word_t    w;
    bit          pinned;
    pixel_word_t res;
  } script_row_t;

  localparam pixel_word_t GROUND_WORD = '{disparity: '0, color: '0, ground: 1'b1};

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [TOL_W-1:0] cfg_data;

  vdgr_in_if  in_ch ();
  vdgr_out_if out_ch ();

  vdisparity_ground_removal u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // line model state, advanced on each accepted word
  logic [TOL_W-1:0]          mdl_tol = TOL_RESET;
  seg_sums_t                 mdl_sums = '0;
  logic [CROW_W-1:0]         mdl_row_tag = ROW_INVALID;
  logic signed [EXP_W-1:0]   mdl_level = '0;

  // segment sums as seen by the stimulus side, to aim pixels at the line
  seg_sums_t   gen_sums = '0;
  pixel_word_t pixel_results [$];

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit rx_hold_req = 1'b0;
  int words_sent = 0;
  int results_checked = 0;
  int ground_hits = 0;
  int n_errors = 0;
  int quiet_cycles = 0;

  function automatic int pick_gap(input bit on);
    int r;
    r = $urandom_range(99);
    if (!on || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic bit line_usable(input seg_sums_t s);
    return s.cnt != 0 && s.row_b != s.row_a;
  endfunction

  function automatic seg_sums_t absorb_segment(input seg_sums_t s, input in_word_t w);
    if (s.cnt < DEF_MAX_SEGMENTS) begin
      s.cnt    = s.cnt + CNT_W'(1);
      s.disp_a = s.disp_a + SUMD_W'(w.seg_disp_a);
      s.row_a  = s.row_a + SUMR_W'(w.seg_row_a);
      s.disp_b = s.disp_b + SUMD_W'(w.seg_disp_b);
      s.row_b  = s.row_b + SUMR_W'(w.seg_row_b);
    end
    return s;
  endfunction

  // expected ground disparity at a row, fixed point, rounded half away, saturated
  function automatic logic signed [EXP_W-1:0] ground_line(input seg_sums_t s,
                                                          input logic [ROW_W-1:0] row);
    longint n, dr, dd, num, den, val;
    longint unsigned mag, uden, q;
    bit neg;
    n   = longint'(s.cnt);
    dr  = longint'(s.row_b) - longint'(s.row_a);
    dd  = longint'(s.disp_b) - longint'(s.disp_a);
    num = longint'(s.disp_b) * dr + (longint'(row) * n - longint'(s.row_b)) * dd;
    den = n * dr;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    neg  = num < 0;
    mag  = neg ? -num : num;
    uden = den;
    q = ((mag << (DEF_FRACTION_BITS + 1)) + uden) / (uden * 2);
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    val = neg ? -longint'(q) : longint'(q);
    if (val > longint'(EXP_MAX)) val = longint'(EXP_MAX);
    if (val < longint'(EXP_MIN)) val = longint'(EXP_MIN);
    return val[EXP_W-1:0];
  endfunction

  function automatic bit classify_word(input in_word_t w, output pixel_word_t r);
    longint diff, lim;
    r = '0;
    case (w.action)
      ACT_CLEAR: begin
        mdl_sums    = '0;
        mdl_row_tag = ROW_INVALID;
        mdl_level   = '0;
        return 1'b0;
      end
      ACT_ADD: begin
        mdl_sums    = absorb_segment(mdl_sums, w);
        mdl_row_tag = ROW_INVALID;
        return 1'b0;
      end
      ACT_PIXEL: begin
        r.disparity = w.pixel_disparity;
        r.color     = w.pixel_color;
        if (w.pixel_row < DEF_MAX_ROWS && line_usable(mdl_sums)) begin
          // recompute the line value only on a row change
          if (mdl_row_tag != {1'b0, w.pixel_row}) begin
            mdl_level   = ground_line(mdl_sums, w.pixel_row);
            mdl_row_tag = {1'b0, w.pixel_row};
          end
          lim  = longint'(mdl_tol) << DEF_FRACTION_BITS;
          diff = (longint'(w.pixel_disparity) << DEF_FRACTION_BITS) - longint'(mdl_level);
          if (diff < 0) diff = -diff;
          if (diff < lim) r = GROUND_WORD;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic in_word_t make_word(input logic [ACTION_W-1:0] act);
    logic [95:0] raw;
    in_word_t w;
    raw = {$urandom(), $urandom(), $urandom()};
    w = raw[$bits(in_word_t)-1:0];
    w.action = act;
    return w;
  endfunction

  function automatic in_word_t seg_word(input logic [DISP_W-1:0] da, input logic [ROW_W-1:0] ra,
                                        input logic [DISP_W-1:0] db, input logic [ROW_W-1:0] rb);
    in_word_t w;
    w = make_word(ACT_ADD);
    w.seg_disp_a = da;
    w.seg_row_a  = ra;
    w.seg_disp_b = db;
    w.seg_row_b  = rb;
    return w;
  endfunction

  function automatic in_word_t pix_word(input logic [ROW_W-1:0] row,
                                        input logic [DISP_W-1:0] disp,
                                        input logic [COLOR_W-1:0] color);
    in_word_t w;
    w = make_word(ACT_PIXEL);
    w.pixel_row       = row;
    w.pixel_disparity = disp;
    w.pixel_color     = color;
    return w;
  endfunction

  function automatic logic [ROW_W-1:0] pick_row();
    int mra, mrb;
    if (!line_usable(gen_sums) || $urandom_range(99) < 35) return ROW_W'($urandom_range(0, 1023));
    mra = gen_sums.row_a / gen_sums.cnt;
    mrb = gen_sums.row_b / gen_sums.cnt;
    return ROW_W'($urandom_range(mra, mrb));
  endfunction

  // most pixels land within a few counts of the line, either side of the tolerance edge
  function automatic logic [DISP_W-1:0] pick_disparity(input logic [ROW_W-1:0] row);
    longint e;
    int c, span;
    if (!line_usable(gen_sums) || $urandom_range(9) < 4) return DISP_W'($urandom_range(0, 255));
    e    = longint'(ground_line(gen_sums, row));
    span = int'(mdl_tol) + 2;
    c = int'((e + 128) >>> DEF_FRACTION_BITS) + int'($urandom_range(0, 2 * span)) - span;
    if (c < 0) c = 0;
    if (c > 255) c = 255;
    return c[DISP_W-1:0];
  endfunction

  task automatic send_word(input in_word_t w, input bit pinned = 1'b0,
                           input pixel_word_t pinned_res = '0);
    int gap;
    pixel_word_t r;
    gap = pick_gap(tx_idle_on);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.action          <= w.action;
    in_ch.seg_disp_a      <= w.seg_disp_a;
    in_ch.seg_row_a       <= w.seg_row_a;
    in_ch.seg_disp_b      <= w.seg_disp_b;
    in_ch.seg_row_b       <= w.seg_row_b;
    in_ch.pixel_row       <= w.pixel_row;
    in_ch.pixel_disparity <= w.pixel_disparity;
    in_ch.pixel_color     <= w.pixel_color;
    if (w.action == ACT_CLEAR) gen_sums = '0;
    else if (w.action == ACT_ADD) gen_sums = absorb_segment(gen_sums, w);
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    if (classify_word(w, r)) pixel_results.push_back(pinned ? pinned_res : r);
    words_sent++;
  endtask

  // hold the input until every pixel word is back, then let the block settle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pixel_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we  <= 1'b0;
    mdl_tol = value;
  endtask

  task automatic run_frame(input int n_seg, input bit level, input int n_pix);
    logic [ROW_W-1:0] row, lr;
    int reps;
    if (n_seg > 8 || $urandom_range(9) != 0) send_word(make_word(ACT_CLEAR));
    repeat (n_seg) begin
      if (level) begin
        lr = ROW_W'($urandom_range(0, 1023));
        send_word(seg_word(DISP_W'($urandom), lr, DISP_W'($urandom), lr));
      end else begin
        send_word(seg_word(DISP_W'($urandom), ROW_W'($urandom),
                           DISP_W'($urandom), ROW_W'($urandom)));
      end
    end
    while (n_pix > 0) begin
      row  = pick_row();
      reps = $urandom_range(1, 5);
      repeat (reps) begin
        send_word(pix_word(row, pick_disparity(row), COLOR_W'($urandom)));
        n_pix--;
      end
      // occasional noise: spare action or a late segment mid-frame
      if ($urandom_range(11) == 0) send_word(make_word(ACT_NONE));
      if ($urandom_range(19) == 0) begin
        send_word(seg_word(DISP_W'($urandom), ROW_W'($urandom),
                           DISP_W'($urandom), ROW_W'($urandom)));
      end
    end
  endtask

  initial begin : result_sink
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        gap = pick_gap(rx_idle_on);
        if (gap != 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    pixel_word_t exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pixel_results.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected pixel word: disp %0d color %06h ground %0b",
                 $time, out_ch.disparity_out, out_ch.color_out, out_ch.is_ground);
      end else begin
        exp_w = pixel_results.pop_front();
        results_checked++;
        if (exp_w.ground) ground_hits++;
        if (out_ch.disparity_out !== exp_w.disparity || out_ch.color_out !== exp_w.color ||
            out_ch.is_ground !== exp_w.ground) begin
          n_errors++;
          $display("%0t: pixel word mismatch: expected disp %0d color %06h ground %0b, got disp %0d color %06h ground %0b",
                   $time, exp_w.disparity, exp_w.color, exp_w.ground,
                   out_ch.disparity_out, out_ch.color_out, out_ch.is_ground);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d pixel words outstanding",
               $time, quiet_cycles, pixel_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    script_row_t script [$];
    int start_words;
    logic [TOL_W-1:0] tol;
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_data              <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.action          <= ACT_CLEAR;
    in_ch.seg_disp_a      <= '0;
    in_ch.seg_row_a       <= '0;
    in_ch.seg_disp_b      <= '0;
    in_ch.seg_row_b       <= '0;
    in_ch.pixel_row       <= '0;
    in_ch.pixel_disparity <= '0;
    in_ch.pixel_color     <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // tolerance is at its reset value of 10 throughout this table
    script = '{
      '{pix_word(0, 0, 24'h000000),          1'b1, '{8'd0, 24'h000000, 1'b0}},
      '{pix_word(1023, 255, 24'hFFFFFF),     1'b1, '{8'd255, 24'hFFFFFF, 1'b0}},
      '{make_word(ACT_NONE),                 1'b0, '0},
      '{seg_word(100, 200, 100, 200),        1'b0, '0},
      '{pix_word(500, 100, 24'h123456),      1'b1, '{8'd100, 24'h123456, 1'b0}},
      '{make_word(ACT_CLEAR),                1'b0, '0},
      '{seg_word(0, 0, 255, 1023),           1'b0, '0},
      '{pix_word(1023, 255, 24'hABCDEF),     1'b1, GROUND_WORD},
      '{pix_word(1023, 245, 24'h00FF00),     1'b1, '{8'd245, 24'h00FF00, 1'b0}},
      '{pix_word(1023, 246, 24'hFF0000),     1'b1, GROUND_WORD},
      '{pix_word(0, 0, 24'hFFFFFF),          1'b1, GROUND_WORD},
      '{pix_word(0, 10, 24'h0000FF),         1'b1, '{8'd10, 24'h0000FF, 1'b0}},
      '{pix_word(512, DISP_W'($urandom), COLOR_W'($urandom)), 1'b0, '0},
      '{pix_word(512, DISP_W'($urandom), COLOR_W'($urandom)), 1'b0, '0},
      '{make_word(ACT_CLEAR),                1'b0, '0},
      '{seg_word(0, 0, 255, 1),              1'b0, '0},
      '{pix_word(1023, 255, 24'h5A5A5A),     1'b1, '{8'd255, 24'h5A5A5A, 1'b0}},
      '{make_word(ACT_CLEAR),                1'b0, '0},
      '{seg_word(255, 0, 0, 1),              1'b0, '0},
      '{pix_word(1023, 0, 24'h0F0F0F),       1'b1, '{8'd0, 24'h0F0F0F, 1'b0}},
      '{seg_word(255, 1023, 255, 1023),      1'b0, '0},
      '{pix_word(700, DISP_W'($urandom), COLOR_W'($urandom)), 1'b0, '0},
      '{make_word(ACT_NONE),                 1'b0, '0},
      '{pix_word(700, DISP_W'($urandom), COLOR_W'($urandom)), 1'b0, '0}
    };
    foreach (script[i]) send_word(script[i].w, script[i].pinned, script[i].res);

    // tolerance extremes, including zero where nothing may be ground
    write_tolerance(8'd0);
    run_frame(3, 1'b0, 12);
    write_tolerance(8'd255);
    run_frame(2, 1'b0, 12);
    write_tolerance(8'd1);
    run_frame(4, 1'b0, 12);

    // overfill the segment set; adds past capacity are dropped
    write_tolerance(8'd6);
    run_frame(DEF_MAX_SEGMENTS + 3, 1'b0, 20);

    // receiver stalls long while the sender keeps offering pixels
    drain_results();
    rx_hold_req = 1'b1;
    tx_idle_on  = 1'b0;
    run_frame(2, 1'b0, 12);
    drain_results();

    start_words = words_sent;
    while (words_sent - start_words < RANDOM_WORDS) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(9))
          0:       tol = 8'd255;
          1:       tol = 8'd1;
          default: tol = TOL_W'($urandom_range(2, 30));
        endcase
        write_tolerance(tol);
      end
      tx_idle_on = $urandom_range(3) != 0;
      rx_idle_on = $urandom_range(3) != 0;
      run_frame($urandom_range(99) < 5 ? 0 : $urandom_range(1, 6),
                $urandom_range(99) < 6, $urandom_range(4, 16));
    end
    drain_results();

    $display("Sent %0d words; checked %0d pixel words, %0d of them ground.",
             words_sent, results_checked, ground_hits);
    $display("Covered tolerance 0/1/255, level and saturated lines, a full segment set.");
    if (n_errors == 0 && pixel_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
